>>> rtl/core/dtis_pkg.sv
// Shared types and constants for the distance tick interval selector.
// No dependencies.
package dtis_pkg;

    localparam int COORD_BITS  = 24;
    localparam int RADIUS_BITS = 23;
    localparam int PERIOD_BITS = 20;
    localparam int FRAC_BITS   = 16;

    localparam logic [1:0] ZONE_NEAR = 2'd0;
    localparam logic [1:0] ZONE_MID  = 2'd1;
    localparam logic [1:0] ZONE_FAR  = 2'd2;

    localparam logic [2:0] REG_NEAR_RADIUS = 3'd0;
    localparam logic [2:0] REG_FAR_RADIUS  = 3'd1;
    localparam logic [2:0] REG_NEAR_PERIOD = 3'd2;
    localparam logic [2:0] REG_MID_PERIOD  = 3'd3;
    localparam logic [2:0] REG_FAR_PERIOD  = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] obj_x;
        logic signed [COORD_BITS-1:0] obj_y;
        logic signed [COORD_BITS-1:0] obj_z;
        logic signed [COORD_BITS-1:0] view_x;
        logic signed [COORD_BITS-1:0] view_y;
        logic signed [COORD_BITS-1:0] view_z;
    } item_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] update_period;
        logic [1:0]             zone;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic [1:0]             zone;
        logic [PERIOD_BITS-1:0] period;
    } side_t;

endpackage

>>> rtl/core/distance_tick_interval_select_top.sv
// Distance tick interval selector, top level.
// Depends on dtis_pkg.
//
// One transaction is accepted per clock and busy is never raised. The receiver
// cannot stall: every result is shown on done/result for exactly one cycle, in
// order. There are 47 register stages from the input to done:
//   - the axis magnitude, square and sum stages;
//   - the compare stage, which loads the root pipe;
//   - 23 square root stages, one root bit each;
//   - the offset stage;
//   - the divider load stage and 16 quotient stages for alpha;
//   - the multiply stage and the output register.
// The configuration registers are read live. Write them only while no
// transaction is in flight.
module distance_tick_interval_select_top
    import dtis_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  item_t         item,
    output logic          done,
    output result_t       result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int MB    = COORD_BITS + 1;        // axis magnitude
    localparam int SUM_W = 2 * MB + 2;
    localparam int SQ_W  = 2 * RADIUS_BITS;       // squared radius width
    localparam int CMP_W = (SUM_W > SQ_W) ? SUM_W : SQ_W;
    localparam int RB    = RADIUS_BITS;           // root bits
    localparam int MUL_W = PERIOD_BITS + FRAC_BITS + 2;

    // ---------------- configuration ----------------
    logic [RB-1:0]          near_radius_reg, far_radius_reg;
    logic [PERIOD_BITS-1:0] near_period_reg, mid_period_reg, far_period_reg;
    logic [SQ_W-1:0]        near_sq_reg, far_sq_reg;
    logic [RB-1:0]          span_reg;
    logic                   cfg_wr;
    logic [2:0]             cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_radius_reg <= RB'(1000);
            far_radius_reg  <= RB'(5000);
            near_period_reg <= '0;
            mid_period_reg  <= PERIOD_BITS'(100000);
            far_period_reg  <= PERIOD_BITS'(500000);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_NEAR_RADIUS: near_radius_reg <= pwdata[RB-1:0];
                REG_FAR_RADIUS:  far_radius_reg  <= pwdata[RB-1:0];
                REG_NEAR_PERIOD: near_period_reg <= pwdata[PERIOD_BITS-1:0];
                REG_MID_PERIOD:  mid_period_reg  <= pwdata[PERIOD_BITS-1:0];
                REG_FAR_PERIOD:  far_period_reg  <= pwdata[PERIOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_NEAR_RADIUS: prdata = 32'(near_radius_reg);
            REG_FAR_RADIUS:  prdata = 32'(far_radius_reg);
            REG_NEAR_PERIOD: prdata = 32'(near_period_reg);
            REG_MID_PERIOD:  prdata = 32'(mid_period_reg);
            REG_FAR_PERIOD:  prdata = 32'(far_period_reg);
            default:         prdata = '0;
        endcase
    end

    // Derived thresholds; registered, they settle in the cycle after a write, before any traffic.
    always_ff @(posedge clk)
    begin
        near_sq_reg <= SQ_W'(near_radius_reg) * SQ_W'(near_radius_reg);
        far_sq_reg  <= SQ_W'(far_radius_reg) * SQ_W'(far_radius_reg);
        span_reg    <= far_radius_reg - near_radius_reg;
    end

    // ---------------- front: diff, square, sum, compare ----------------
    logic             v0_reg, v1_reg, v2_reg;
    logic [MB-1:0]    ax_reg, ay_reg, az_reg;
    logic [2*MB-1:0]  sx_reg, sy_reg, sz_reg;
    logic [SUM_W-1:0] d2_reg;
    logic signed [MB-1:0] dx, dy, dz;

    assign dx = MB'(item.obj_x) - MB'(item.view_x);
    assign dy = MB'(item.obj_y) - MB'(item.view_y);
    assign dz = MB'(item.obj_z) - MB'(item.view_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= dx[MB-1] ? MB'(-dx) : MB'(dx);
        ay_reg <= dy[MB-1] ? MB'(-dy) : MB'(dy);
        az_reg <= dz[MB-1] ? MB'(-dz) : MB'(dz);
        sx_reg <= (2*MB)'(ax_reg) * (2*MB)'(ax_reg);
        sy_reg <= (2*MB)'(ay_reg) * (2*MB)'(ay_reg);
        sz_reg <= (2*MB)'(az_reg) * (2*MB)'(az_reg);
        d2_reg <= SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);
    end

    // Zone decision; near/far periods ride along beside the middle-band math.
    logic [CMP_W-1:0] d2_ext;
    side_t            cmp_side;

    assign d2_ext = CMP_W'(d2_reg);

    always_comb
    begin
        cmp_side.valid = v2_reg;
        if (d2_ext <= CMP_W'(near_sq_reg))
        begin
            cmp_side.zone   = ZONE_NEAR;
            cmp_side.period = near_period_reg;
        end
        else if (d2_ext >= CMP_W'(far_sq_reg))
        begin
            cmp_side.zone   = ZONE_FAR;
            cmp_side.period = far_period_reg;
        end
        else
        begin
            cmp_side.zone   = ZONE_MID;
            cmp_side.period = '0;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    side_t           sq_side_reg [0:RB];
    logic [SQ_W-1:0] sq_val_reg  [0:RB];
    logic [RB+1:0]   sq_rem_reg  [0:RB];
    logic [RB-1:0]   sq_root_reg [0:RB];
    logic [RB+4:0]   sq_cat      [0:RB-1];
    logic [RB+4:0]   sq_trial    [0:RB-1];

    always_comb
    begin
        for (int k = 0; k < RB; k++)
        begin
            sq_cat[k]   = {1'b0, sq_rem_reg[k], sq_val_reg[k][SQ_W-1-2*k -: 2]};
            sq_trial[k] = sq_cat[k] - {3'b000, sq_root_reg[k], 2'b01};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RB; k++)
                sq_side_reg[k] <= '0;
        end
        else
        begin
            sq_side_reg[0] <= cmp_side;
            for (int k = 0; k < RB; k++)
                sq_side_reg[k+1] <= sq_side_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_val_reg[0]         <= d2_ext[SQ_W-1:0];
        sq_rem_reg[0]         <= '0;
        sq_root_reg[0]        <= '0;
        for (int k = 0; k < RB; k++)
        begin
            sq_val_reg[k+1]         <= sq_val_reg[k];
            if (sq_trial[k][RB+4])
            begin
                sq_rem_reg[k+1]  <= sq_cat[k][RB+1:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][RB-2:0], 1'b0};
            end
            else
            begin
                sq_rem_reg[k+1]  <= sq_trial[k][RB+1:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][RB-2:0], 1'b1};
            end
        end
    end

    // ---------------- offset past near radius ----------------
    side_t         off_side_reg;
    logic [RB-1:0] off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            off_side_reg <= '0;
        else
            off_side_reg <= sq_side_reg[RB];
    end

    always_ff @(posedge clk)
    begin
        off_reg             <= sq_root_reg[RB] - near_radius_reg;
    end

    // ---------------- alpha: restoring divide, one bit per stage ----------------
    // In the middle band off < span, so the quotient fits FRAC_BITS.
    side_t                dv_side_reg [0:FRAC_BITS];
    logic [RB-1:0]        dv_rem_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] dv_q_reg    [0:FRAC_BITS];
    logic [RB:0]          dv_sh       [0:FRAC_BITS-1];
    logic [RB:0]          dv_diff     [0:FRAC_BITS-1];
    logic                 dv_ge       [0:FRAC_BITS-1];

    always_comb
    begin
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            dv_sh[k]   = {dv_rem_reg[k], 1'b0};
            dv_ge[k]   = dv_sh[k] >= (RB+1)'(span_reg);
            dv_diff[k] = dv_sh[k] - (RB+1)'(span_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FRAC_BITS; k++)
                dv_side_reg[k] <= '0;
        end
        else
        begin
            dv_side_reg[0] <= off_side_reg;
            for (int k = 0; k < FRAC_BITS; k++)
                dv_side_reg[k+1] <= dv_side_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]         <= off_reg;
        dv_q_reg[0]           <= '0;
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            dv_rem_reg[k+1] <= dv_ge[k] ? dv_diff[k][RB-1:0] : dv_sh[k][RB-1:0];
            dv_q_reg[k+1]   <= {dv_q_reg[k][FRAC_BITS-2:0], dv_ge[k]};
        end
    end

    // ---------------- lerp: products, then sum and truncate ----------------
    side_t           mul_side_reg;
    logic [MUL_W-1:0] pm_reg, pf_reg;
    logic [FRAC_BITS-1:0] alpha;

    assign alpha = dv_q_reg[FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_side_reg <= '0;
        else
            mul_side_reg <= dv_side_reg[FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        pm_reg <= MUL_W'(mid_period_reg)
                  * MUL_W'((FRAC_BITS+1)'(1) << FRAC_BITS) - MUL_W'(mid_period_reg)
                  * MUL_W'(alpha);
        pf_reg <= MUL_W'(far_period_reg) * MUL_W'(alpha);
    end

    logic [MUL_W-1:0] lerp_sum;

    assign lerp_sum = pm_reg + pf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= mul_side_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        result.zone <= mul_side_reg.zone;
        if (mul_side_reg.zone == ZONE_MID)
            result.update_period <= lerp_sum[FRAC_BITS +: PERIOD_BITS];
        else
            result.update_period <= mul_side_reg.period;
    end

endmodule

>>> bench/tb_distance_tick_interval_select_top.sv
// Testbench for distance_tick_interval_select_top: distance-zone update-period predictor,
// APB register programming, random items with idle gaps, in-order result checking.
// Depends on dtis_pkg and the top-level RTL.
module tb_distance_tick_interval_select_top
    import dtis_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

class period_scoreboard;
    logic [RADIUS_BITS-1:0] near_r;
    logic [RADIUS_BITS-1:0] far_r;
    logic [PERIOD_BITS-1:0] near_p;
    logic [PERIOD_BITS-1:0] mid_p;
    logic [PERIOD_BITS-1:0] far_p;
    result_t                expected_q[$];
    int                     mismatches;

    function new();
        near_r     = 23'd1000;
        far_r      = 23'd5000;
        near_p     = '0;
        mid_p      = 20'd100000;
        far_p      = 20'd500000;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_NEAR_RADIUS: near_r = val[RADIUS_BITS-1:0];
            REG_FAR_RADIUS:  far_r  = val[RADIUS_BITS-1:0];
            REG_NEAR_PERIOD: near_p = val[PERIOD_BITS-1:0];
            REG_MID_PERIOD:  mid_p  = val[PERIOD_BITS-1:0];
            REG_FAR_PERIOD:  far_p  = val[PERIOD_BITS-1:0];
            default: ;
        endcase
    endfunction

    function longint unsigned axis_sq(logic signed [COORD_BITS-1:0] a,
                                      logic signed [COORD_BITS-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return longint'(unsigned'(d)) * d;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Expected period and zone for one object/viewer pair
    function void note_item(item_t it);
        longint unsigned d2, near_sq, far_sq, root_d, span, off, alpha, acc;
        result_t         r;
        d2 = axis_sq(it.obj_x, it.view_x) + axis_sq(it.obj_y, it.view_y)
             + axis_sq(it.obj_z, it.view_z);
        near_sq = longint'(near_r) * near_r;
        far_sq  = longint'(far_r) * far_r;
        if (d2 <= near_sq) begin
            r.update_period = near_p;
            r.zone          = ZONE_NEAR;
        end else if (d2 >= far_sq) begin
            r.update_period = far_p;
            r.zone          = ZONE_FAR;
        end else begin
            root_d = isqrt(d2);
            span   = (far_r > near_r) ? longint'(far_r - near_r) : 1;
            off    = (root_d > near_r) ? root_d - near_r : 0;
            alpha  = (off << FRAC_BITS) / span;
            if (alpha > 65535)
                alpha = 65535;
            acc = (longint'(mid_p) * (65536 - alpha) + longint'(far_p) * alpha) >> FRAC_BITS;
            r.update_period = acc[PERIOD_BITS-1:0];
            r.zone          = ZONE_MID;
        end
        expected_q.push_back(r);
    endfunction

    function void report(string what, result_t exp_r, result_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected period %0d zone %0d, got period %0d zone %0d",
                     what, exp_r.update_period, exp_r.zone, got_r.update_period, got_r.zone);
    endfunction

    function void check(result_t got_r);
        result_t exp_r;
        if (expected_q.size() == 0) begin
            report("unexpected result", '0, got_r);
            return;
        end
        exp_r = expected_q.pop_front();
        if (got_r.update_period !== exp_r.update_period)
            report("update_period", exp_r, got_r);
        if (got_r.zone !== exp_r.zone)
            report("zone", exp_r, got_r);
    endfunction
endclass

    localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    period_scoreboard sb;
    int               idle_cycles;
    bit               no_gaps;

    distance_tick_interval_select_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor: both transaction sides plus the idle watchdog.
    // Reads in this block see pre-edge values since all drives are nonblocking.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                sb.note_item(item);
            if (done)
                sb.check(result);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // APB write with setup and access phases; the scoreboard copy follows at the access edge.
    // The bus goes idle before the task returns, so back-to-back writes never collide.
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every expected result is back, then let the pipe empty.
    task automatic wait_idle();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Present one transaction and wait for acceptance, then an optional gap.
    // start stays high across back-to-back items, never dropped and raised in one step.
    task automatic send(item_t it);
        int sel;
        int gap;
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (!(start && !busy));
        sel = $urandom_range(0, 99);
        if (no_gaps || sel < 60)
            gap = 0;
        else if (sel < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic item_t make_item(int ox, int oy, int oz, int vx, int vy, int vz);
        item_t it;
        it.obj_x  = COORD_BITS'(ox);
        it.obj_y  = COORD_BITS'(oy);
        it.obj_z  = COORD_BITS'(oz);
        it.view_x = COORD_BITS'(vx);
        it.view_y = COORD_BITS'(vy);
        it.view_z = COORD_BITS'(vz);
        return it;
    endfunction

    // Random pair: mostly offsets scaled to the current radii so all three
    // zones show up, plus full-range noise and exact boundary distances.
    function automatic item_t rand_item();
        item_t       it;
        int          mode;
        int unsigned reach;
        logic [23:0] d;
        it    = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        mode  = $urandom_range(0, 9);
        reach = (sb.far_r > sb.near_r) ? 32'(sb.far_r) : 32'(sb.near_r);
        reach = (reach < 2) ? 2 : reach;
        if (mode < 6) begin
            d = 24'($urandom_range(0, reach));
            it.obj_x = it.view_x + ($urandom_range(0, 1) ? d : -d);
            d = 24'($urandom_range(0, reach));
            it.obj_y = it.view_y + ($urandom_range(0, 1) ? d : -d);
            d = 24'($urandom_range(0, reach));
            it.obj_z = it.view_z + ($urandom_range(0, 1) ? d : -d);
        end else if (mode < 8) begin
            // Single-axis offset right at a radius, plus or minus one
            d = 24'(($urandom_range(0, 1) ? 32'(sb.near_r) : 32'(sb.far_r))
                    + $urandom_range(0, 2) - 1);
            it.view_x = COORD_BITS'($urandom_range(0, 4000000));
            it.obj_x  = it.view_x - d;
            it.obj_y  = it.view_y;
            it.obj_z  = it.view_z;
        end
        return it;
    endfunction

    initial
    begin
        logic [31:0] cfg [5][5];
        int          n;
        sb          = new();
        idle_cycles = 0;
        no_gaps     = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings: zero distance, extremes, radius boundaries
        send(make_item(0, 0, 0, 0, 0, 0));
        send(make_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000));
        send(make_item(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send(make_item(1000, 0, 0, 0, 0, 0));
        send(make_item(1001, 0, 0, 0, 0, 0));
        send(make_item(4999, 0, 0, 0, 0, 0));
        send(make_item(5000, 0, 0, 0, 0, 0));
        send(make_item(-3000, 0, 0, 0, 0, 0));
        send(make_item(0, -2000, 2000, 0, 0, 0));
        send(make_item(24'hFFFFFF, 0, 0, 24'h7FFFFF, 0, 0));
        send(make_item(100, 200, 300, -3500, 1200, 2200));
        send(make_item(24'h800000, 0, 0, 24'h800000, 24'hFFFFFF, 0));
        start <= 1'b0;
        @(posedge clk);

        // Settings: reset values, equal zero radii, near above far,
        // widest band with extreme periods, full-width register writes (masked)
        cfg[0] = '{1000, 5000, 0, 100000, 500000};
        cfg[1] = '{0, 0, 1000000, 0, 1000000};
        cfg[2] = '{40000, 300, 777, 12345, 54321};
        cfg[3] = '{0, 8388607, 0, 1000000, 0};
        cfg[4] = '{32'hFFFF_FFFF, 32'h0080_1F40, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00F0_0000};

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            reg_write(REG_NEAR_RADIUS, cfg[ph][0]);
            reg_write(REG_FAR_RADIUS,  cfg[ph][1]);
            reg_write(REG_NEAR_PERIOD, cfg[ph][2]);
            reg_write(REG_MID_PERIOD,  cfg[ph][3]);
            reg_write(REG_FAR_PERIOD,  cfg[ph][4]);
            @(posedge clk);
            no_gaps = (ph % 2 == 1);
            n       = 200;
            for (int i = 0; i < n; i++)
                send(rand_item());
            start <= 1'b0;
            @(posedge clk);
        end

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
